>>> hw/rtl/interval_locate_interp_weights_defines.svh
// assertion macros for the checker file
`ifndef INTERVAL_LOCATE_INTERP_WEIGHTS_DEFINES_SVH
`define INTERVAL_LOCATE_INTERP_WEIGHTS_DEFINES_SVH

// checked on every rising edge outside reset
`define ILW_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// checked on every rising edge, reset included
`define ILW_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

>>> hw/rtl/ilw_pkg.sv
package ilw_pkg;

  localparam int TABLE_DEPTH_DEF = 64;
  localparam int FRAC_BITS_DEF   = 16;

  localparam int TIME_W    = 32;
  localparam int PERIOD_W  = 31;
  localparam int COUNT_W   = 7;
  localparam int IDX_W     = 6;
  localparam int WGT_W     = 17;
  localparam int CFG_IDX_W = 2;
  localparam int S_DATA_W  = 72;
  localparam int M_DATA_W  = 48;

  localparam logic [PERIOD_W-1:0] PERIOD_RST = PERIOD_W'(65536);
  localparam logic [COUNT_W-1:0]  COUNT_RST  = COUNT_W'(2);

  localparam logic KIND_WRITE = 1'b0;
  localparam logic KIND_QUERY = 1'b1;

  localparam logic [CFG_IDX_W-1:0] REG_MODE   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_COUNT  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_PERIOD = 2'd2;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_BELOW = 2'd1,
    ST_ABOVE = 2'd2,
    ST_FLAT  = 2'd3
  } status_t;

  typedef struct packed {
    logic                     kind;
    logic [IDX_W-1:0]         idx;
    logic signed [TIME_W-1:0] value;
  } item_t;

  typedef struct packed {
    logic                periodic;
    logic [PERIOD_W-1:0] period;
  } mod_cfg_t;

endpackage

>>> hw/rtl/interval_locate_interp_weights.sv
// Piecewise-linear interpolation weights. Items on the s_ side either load one
// breakpoint time (tuser 0) or query a signed Q16.16 time (tuser 1); every item
// gives exactly one result item on the m_ side, in order. A query finds the
// table interval that brackets the time and returns both indices plus the
// weights (hi-t)/(hi-lo) and one minus that, truncated, with FRAC_BITS fraction
// bits. In periodic mode the time is first reduced modulo the period and the
// indices skip the pad entry at each end of the table. The block takes one item
// per clock while the output is not stalled and no breakpoint write is held.
// The modulo unit computes one remainder bit per stage, the table search and
// read follow, and the divider computes one quotient bit per stage.
// A breakpoint write waits at the table stage until the three stages after it
// are empty, so items ahead have read the table; output stalls lengthen the
// wait. Breakpoints never written read as unknown. Configuration must be
// written only while no items are in flight; the block does not enforce this.
module interval_locate_interp_weights #(
  parameter int TABLE_DEPTH = ilw_pkg::TABLE_DEPTH_DEF,
  parameter int FRAC_BITS   = ilw_pkg::FRAC_BITS_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  // input items
  input  logic                            s_tvalid,
  output logic                            s_tready,
  // entry_index[5:0], entry_time[37:6], query_time[69:38], zero pad [71:70]
  input  logic [ilw_pkg::S_DATA_W-1:0]    s_tdata,
  // kind[0]
  input  logic                            s_tuser,
  // result items
  output logic                            m_tvalid,
  input  logic                            m_tready,
  // index_low[5:0], index_high[11:6], weight_low[28:12], weight_high[45:29],
  // zero pad [47:46]
  output logic [ilw_pkg::M_DATA_W-1:0]    m_tdata,
  // status[1:0]
  output logic [1:0]                      m_tuser,
  // register writes
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [ilw_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [ilw_pkg::PERIOD_W-1:0]    cfg_data
);

  localparam int AW = $clog2(TABLE_DEPTH);
  localparam int IW = ilw_pkg::IDX_W;
  localparam int WW = ilw_pkg::WGT_W;

  // configuration registers
  logic                            periodic_mode;
  logic [ilw_pkg::COUNT_W-1:0]     table_count;
  logic [ilw_pkg::PERIOD_W-1:0]    period;

  ilw_pkg::mod_cfg_t mod_cfg;
  ilw_pkg::item_t    in_item;
  ilw_pkg::item_t    mod_item;
  logic              mod_valid, mod_ready;

  logic              loc_valid, loc_ready;
  ilw_pkg::status_t  loc_status;
  logic [AW-1:0]     loc_ilo, loc_ihi;
  logic [ilw_pkg::TIME_W-1:0] loc_num, loc_den;
  logic              loc_wz;

  ilw_pkg::status_t  res_status;
  logic [AW-1:0]     res_ilo, res_ihi;
  logic [FRAC_BITS:0] res_wl, res_wh;

  logic [IW+AW-1:0]        ilo_wide, ihi_wide;
  logic [WW+FRAC_BITS:0]   wl_wide, wh_wide;

  // registers are always writable; an unknown index is dropped
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      periodic_mode <= 1'b0;
      table_count   <= ilw_pkg::COUNT_RST;
      period        <= ilw_pkg::PERIOD_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        ilw_pkg::REG_MODE:   periodic_mode <= cfg_data[0];
        ilw_pkg::REG_COUNT:  table_count   <= cfg_data[ilw_pkg::COUNT_W-1:0];
        ilw_pkg::REG_PERIOD: period        <= cfg_data;
        default: ;
      endcase
    end
  end

  assign mod_cfg.periodic = periodic_mode;
  assign mod_cfg.period   = period;

  // a write carries its breakpoint time, a query its lookup time
  assign in_item.kind  = s_tuser;
  assign in_item.idx   = s_tdata[5:0];
  assign in_item.value = (s_tuser == ilw_pkg::KIND_QUERY) ? s_tdata[69:38] : s_tdata[37:6];

  // time reduction modulo the period
  ilw_mod u_mod (
    .clk       (clk),
    .rst       (rst),
    .cfg       (mod_cfg),
    .in_valid  (s_tvalid),
    .in_ready  (s_tready),
    .in_item   (in_item),
    .out_valid (mod_valid),
    .out_ready (mod_ready),
    .out_item  (mod_item)
  );

  // breakpoint storage, interval search, index mapping
  ilw_locate #(
    .DEPTH (TABLE_DEPTH)
  ) u_locate (
    .clk         (clk),
    .rst         (rst),
    .periodic    (periodic_mode),
    .table_count (table_count),
    .in_valid    (mod_valid),
    .in_ready    (mod_ready),
    .in_item     (mod_item),
    .out_valid   (loc_valid),
    .out_ready   (loc_ready),
    .out_status  (loc_status),
    .out_ilo     (loc_ilo),
    .out_ihi     (loc_ihi),
    .out_num     (loc_num),
    .out_den     (loc_den),
    .out_wz      (loc_wz)
  );

  // weight division; its last stage is the output register
  ilw_div #(
    .FRAC_BITS (FRAC_BITS),
    .AW        (AW)
  ) u_div (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (loc_valid),
    .in_ready   (loc_ready),
    .in_status  (loc_status),
    .in_ilo     (loc_ilo),
    .in_ihi     (loc_ihi),
    .in_num     (loc_num),
    .in_den     (loc_den),
    .in_wz      (loc_wz),
    .out_valid  (m_tvalid),
    .out_ready  (m_tready),
    .out_status (res_status),
    .out_ilo    (res_ilo),
    .out_ihi    (res_ihi),
    .out_wl     (res_wl),
    .out_wh     (res_wh)
  );

  // fit indices and weights to the port field widths
  assign ilo_wide = {{IW{1'b0}}, res_ilo};
  assign ihi_wide = {{IW{1'b0}}, res_ihi};
  assign wl_wide  = {{WW{1'b0}}, res_wl};
  assign wh_wide  = {{WW{1'b0}}, res_wh};

  assign m_tdata = {2'b00, wh_wide[WW-1:0], wl_wide[WW-1:0], ihi_wide[IW-1:0], ilo_wide[IW-1:0]};
  assign m_tuser = res_status;

endmodule

>>> hw/rtl/ilw_mod.sv
module ilw_mod (
  input  logic             clk,
  input  logic             rst,
  input  ilw_pkg::mod_cfg_t cfg,
  input  logic             in_valid,
  output logic             in_ready,
  input  ilw_pkg::item_t   in_item,
  output logic             out_valid,
  input  logic             out_ready,
  output ilw_pkg::item_t   out_item
);

  localparam int TW = ilw_pkg::TIME_W;
  localparam int PW = ilw_pkg::PERIOD_W;
  localparam int NB = TW;
  localparam int S  = NB + 2;

  logic           v   [S];
  logic           rdy [S+1];
  ilw_pkg::item_t it  [S];
  logic [TW-1:0]  mag [S-1];
  logic [PW-1:0]  rem [S-1];
  logic           neg [S-1];

  logic [TW-1:0] in_mag;
  logic [PW-1:0] r_fin;
  logic [PW-1:0] r_fix;
  logic          use_mod;
  ilw_pkg::item_t it_next;

  assign in_mag = in_item.value[TW-1] ? (~in_item.value + TW'(1)) : in_item.value;

  genvar k;
  generate
    for (k = 0; k < S; k++) begin : g_rdy
      assign rdy[k] = !v[k] || rdy[k+1];
    end
  endgenerate

  assign rdy[S]    = out_ready;
  assign in_ready  = rdy[0];
  assign out_valid = v[S-1];
  assign out_item  = it[S-1];

  // input stage: magnitude of the time
  always_ff @(posedge clk) begin
    if (rst) begin
      v[0] <= 1'b0;
    end else if (rdy[0]) begin
      v[0] <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy[0] && in_valid) begin
      it[0]  <= in_item;
      mag[0] <= in_mag;
      rem[0] <= '0;
      neg[0] <= in_item.value[TW-1];
    end
  end

  // one remainder bit per stage
  generate
    for (k = 1; k <= NB; k++) begin : g_bit
      logic [PW:0] cand;
      logic [PW:0] diff;
      logic        ge;

      assign cand = {rem[k-1], mag[k-1][TW-1]};
      assign diff = cand - {1'b0, cfg.period};
      assign ge   = cand >= {1'b0, cfg.period};

      always_ff @(posedge clk) begin
        if (rst) begin
          v[k] <= 1'b0;
        end else if (rdy[k]) begin
          v[k] <= v[k-1];
        end
      end

      always_ff @(posedge clk) begin
        if (rdy[k] && v[k-1]) begin
          it[k]  <= it[k-1];
          neg[k] <= neg[k-1];
          mag[k] <= mag[k-1] << 1;
          rem[k] <= ge ? diff[PW-1:0] : cand[PW-1:0];
        end
      end
    end
  endgenerate

  // sign fix: a negative time wraps to period minus remainder
  assign r_fin   = rem[NB];
  assign r_fix   = (neg[NB] && r_fin != '0) ? cfg.period - r_fin : r_fin;
  assign use_mod = (it[NB].kind == ilw_pkg::KIND_QUERY) && cfg.periodic && (cfg.period != '0);

  always_comb begin
    it_next = it[NB];
    if (use_mod) begin
      it_next.value = $signed({1'b0, r_fix});
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v[S-1] <= 1'b0;
    end else if (rdy[S-1]) begin
      v[S-1] <= v[S-2];
    end
  end

  always_ff @(posedge clk) begin
    if (rdy[S-1] && v[S-2]) begin
      it[S-1] <= it_next;
    end
  end

endmodule

>>> hw/rtl/ilw_locate.sv
module ilw_locate #(
  parameter  int DEPTH = ilw_pkg::TABLE_DEPTH_DEF,
  localparam int AW    = $clog2(DEPTH)
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          periodic,
  input  logic [ilw_pkg::COUNT_W-1:0]   table_count,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  ilw_pkg::item_t                in_item,
  output logic                          out_valid,
  input  logic                          out_ready,
  output ilw_pkg::status_t              out_status,
  output logic [AW-1:0]                 out_ilo,
  output logic [AW-1:0]                 out_ihi,
  output logic [ilw_pkg::TIME_W-1:0]    out_num,
  output logic [ilw_pkg::TIME_W-1:0]    out_den,
  output logic                          out_wz
);

  localparam int TW = ilw_pkg::TIME_W;
  localparam int CW = ($clog2(DEPTH + 1) > ilw_pkg::COUNT_W) ? $clog2(DEPTH + 1)
                                                               : ilw_pkg::COUNT_W;
  localparam int NG = (DEPTH + 7) / 8;
  localparam int S  = 6;

  logic v   [S];
  logic rdy [S+1];
  logic hold;

  logic [CW-1:0] cnt_c;
  logic [CW-1:0] min_c;
  logic [CW-1:0] cm1;
  logic [CW-1:0] cm2;
  logic [CW-1:0] cm3;

  logic signed [TW-1:0] bank [DEPTH];
  logic signed [TW-1:0] mem  [DEPTH];

  ilw_pkg::item_t it0, it1, it2, it3, it4;
  logic [DEPTH-1:0] le_c, lt_c, le1, lt1;
  logic [NG*8-1:0]  h;
  logic [NG-1:0]    ghit_c, ghit2;
  logic [2:0]       gsel_c [NG];
  logic [2:0]       gsel2  [NG];
  logic             below2, above2, below3, above3, below4, above4;
  logic [AW-1:0]    found_c, found3, found4;
  logic signed [TW-1:0] lo4, hi4;

  logic [ilw_pkg::IDX_W+AW-1:0] idx_wide;
  logic [AW-1:0]  wr_addr;
  logic           wr_en;
  logic           move01;

  logic signed [TW:0] den_w, num_w;
  logic [AW-1:0]      i1, i2;
  ilw_pkg::status_t   st_c;
  logic [AW-1:0]      ilo_c, ihi_c;
  logic [TW-1:0]      num_c, den_c;
  logic               wz_c;

  // entries in use, clamped
  always_comb begin
    min_c = periodic ? CW'(3) : CW'(2);
    cnt_c = CW'(table_count);
    if (cnt_c < min_c) begin
      cnt_c = min_c;
    end
    if (cnt_c > CW'(DEPTH)) begin
      cnt_c = CW'(DEPTH);
    end
    cm1 = cnt_c - CW'(1);
    cm2 = cnt_c - CW'(2);
    cm3 = cnt_c - CW'(3);
  end

  genvar k;
  generate
    for (k = 0; k < S; k++) begin : g_rdy
      if (k == 0) begin : g_head
        assign rdy[k] = !v[k] || (rdy[k+1] && !hold);
      end else begin : g_body
        assign rdy[k] = !v[k] || rdy[k+1];
      end
    end
  endgenerate

  assign rdy[S]    = out_ready;
  assign in_ready  = rdy[0];
  assign out_valid = v[S-1];

  // a write waits until items ahead have read the table
  assign hold   = v[0] && (it0.kind == ilw_pkg::KIND_WRITE) && (v[1] || v[2] || v[3]);
  assign move01 = v[0] && rdy[1] && !hold;

  always_ff @(posedge clk) begin
    if (rst) begin
      v[0] <= 1'b0;
      v[1] <= 1'b0;
      v[2] <= 1'b0;
      v[3] <= 1'b0;
      v[4] <= 1'b0;
      v[5] <= 1'b0;
    end else begin
      if (rdy[0]) begin
        v[0] <= in_valid;
      end
      if (rdy[1]) begin
        v[1] <= v[0] && !hold;
      end
      if (rdy[2]) begin
        v[2] <= v[1];
      end
      if (rdy[3]) begin
        v[3] <= v[2];
      end
      if (rdy[4]) begin
        v[4] <= v[3];
      end
      if (rdy[5]) begin
        v[5] <= v[4];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rdy[0] && in_valid) begin
      it0 <= in_item;
    end
  end

  // breakpoint write, into the compare bank and the read memory
  assign idx_wide = {{AW{1'b0}}, it0.idx};
  assign wr_addr  = idx_wide[AW-1:0];
  assign wr_en    = move01 && (it0.kind == ilw_pkg::KIND_WRITE) && (32'(it0.idx) < DEPTH);

  always_ff @(posedge clk) begin
    if (wr_en) begin
      bank[wr_addr] <= it0.value;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= it0.value;
    end
  end

  generate
    for (k = 0; k < DEPTH; k++) begin : g_cmp
      assign le_c[k] = bank[k] <= it0.value;
      assign lt_c[k] = bank[k] <  it0.value;
    end
  endgenerate

  always_ff @(posedge clk) begin
    if (move01) begin
      it1 <= it0;
      le1 <= le_c;
      lt1 <= lt_c;
    end
  end

  // interval hits, first hit inside each group of eight
  always_comb begin
    h = '0;
    for (int i = 0; i < DEPTH - 1; i++) begin
      h[i] = le1[i] && !le1[i+1] && (CW'(i) < cm1);
    end
    for (int g = 0; g < NG; g++) begin
      ghit_c[g] = |h[g*8 +: 8];
      gsel_c[g] = 3'd0;
      for (int j = 7; j >= 0; j--) begin
        if (h[g*8 + j]) begin
          gsel_c[g] = 3'(j);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rdy[2] && v[1]) begin
      it2    <= it1;
      ghit2  <= ghit_c;
      gsel2  <= gsel_c;
      below2 <= !le1[0];
      above2 <= lt1[cm1[AW-1:0]];
    end
  end

  always_comb begin
    found_c = cm2[AW-1:0];
    for (int g = NG - 1; g >= 0; g--) begin
      if (ghit2[g]) begin
        found_c = AW'(g * 8 + int'(gsel2[g]));
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rdy[3] && v[2]) begin
      it3    <= it2;
      found3 <= found_c;
      below3 <= below2;
      above3 <= above2;
    end
  end

  // bracketing breakpoints
  always_ff @(posedge clk) begin
    if (rdy[4] && v[3]) begin
      lo4 <= mem[found3];
      hi4 <= mem[AW'(found3 + AW'(1))];
    end
  end

  always_ff @(posedge clk) begin
    if (rdy[4] && v[3]) begin
      it4    <= it3;
      found4 <= found3;
      below4 <= below3;
      above4 <= above3;
    end
  end

  always_comb begin
    den_w = $signed({hi4[TW-1], hi4}) - $signed({lo4[TW-1], lo4});
    num_w = $signed({hi4[TW-1], hi4}) - $signed({it4.value[TW-1], it4.value});

    if (periodic) begin
      if (found4 == '0) begin
        i1 = cm3[AW-1:0];
        i2 = '0;
      end else begin
        i1 = found4 - AW'(1);
        i2 = (i1 == cm3[AW-1:0]) ? '0 : found4;
      end
    end else begin
      i1 = found4;
      i2 = AW'(found4 + AW'(1));
    end

    // a unit quotient gives a full low weight on a flat interval
    st_c  = ilw_pkg::ST_OK;
    ilo_c = '0;
    ihi_c = '0;
    num_c = '0;
    den_c = TW'(1);
    wz_c  = 1'b1;
    if (it4.kind == ilw_pkg::KIND_WRITE) begin
      st_c = ilw_pkg::ST_OK;
    end else if (below4) begin
      st_c = ilw_pkg::ST_BELOW;
    end else if (above4) begin
      st_c = ilw_pkg::ST_ABOVE;
    end else if (den_w <= 0) begin
      st_c  = ilw_pkg::ST_FLAT;
      ilo_c = i1;
      ihi_c = i2;
      num_c = TW'(1);
    end else begin
      ilo_c = i1;
      ihi_c = i2;
      den_c = den_w[TW-1:0];
      wz_c  = 1'b0;
      if (num_w < 0) begin
        num_c = '0;
      end else if (num_w > den_w) begin
        num_c = den_w[TW-1:0];
      end else begin
        num_c = num_w[TW-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rdy[5] && v[4]) begin
      out_status <= st_c;
      out_ilo    <= ilo_c;
      out_ihi    <= ihi_c;
      out_num    <= num_c;
      out_den    <= den_c;
      out_wz     <= wz_c;
    end
  end

endmodule

>>> hw/rtl/ilw_div.sv
module ilw_div #(
  parameter int FRAC_BITS = ilw_pkg::FRAC_BITS_DEF,
  parameter int AW        = 6
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  ilw_pkg::status_t           in_status,
  input  logic [AW-1:0]              in_ilo,
  input  logic [AW-1:0]              in_ihi,
  input  logic [ilw_pkg::TIME_W-1:0] in_num,
  input  logic [ilw_pkg::TIME_W-1:0] in_den,
  input  logic                       in_wz,
  output logic                       out_valid,
  input  logic                       out_ready,
  output ilw_pkg::status_t           out_status,
  output logic [AW-1:0]              out_ilo,
  output logic [AW-1:0]              out_ihi,
  output logic [FRAC_BITS:0]         out_wl,
  output logic [FRAC_BITS:0]         out_wh
);

  localparam int TW = ilw_pkg::TIME_W;
  localparam int MW = 2 + 2 * AW + 1;
  localparam int NQ = FRAC_BITS + 1;
  localparam int S  = NQ + 2;
  localparam logic [FRAC_BITS:0] ONE = {1'b1, {FRAC_BITS{1'b0}}};

  logic             v    [S];
  logic             rdy  [S+1];
  logic [MW-1:0]    meta [S];
  logic [TW-1:0]    rem  [S-1];
  logic [TW-1:0]    den  [S-1];
  logic [FRAC_BITS:0] q  [S-1];
  logic [FRAC_BITS:0] wl_f, wh_f;

  genvar k;
  generate
    for (k = 0; k < S; k++) begin : g_rdy
      assign rdy[k] = !v[k] || rdy[k+1];
    end
  endgenerate

  assign rdy[S]     = out_ready;
  assign in_ready   = rdy[0];
  assign out_valid  = v[S-1];
  assign out_status = ilw_pkg::status_t'(meta[S-1][MW-1 -: 2]);
  assign out_ilo    = meta[S-1][2*AW:AW+1];
  assign out_ihi    = meta[S-1][AW:1];
  assign out_wl     = wl_f;
  assign out_wh     = wh_f;

  always_ff @(posedge clk) begin
    if (rst) begin
      v[0] <= 1'b0;
    end else if (rdy[0]) begin
      v[0] <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy[0] && in_valid) begin
      meta[0] <= {in_status, in_ilo, in_ihi, in_wz};
      rem[0]  <= in_num;
      den[0]  <= in_den;
      q[0]    <= '0;
    end
  end

  // one quotient bit per stage, integer bit first
  generate
    for (k = 1; k <= NQ; k++) begin : g_bit
      logic [TW:0] cand;
      logic [TW:0] diff;
      logic        ge;

      if (k == 1) begin : g_first
        assign cand = {1'b0, rem[k-1]};
      end else begin : g_next
        assign cand = {rem[k-1], 1'b0};
      end
      assign diff = cand - {1'b0, den[k-1]};
      assign ge   = cand >= {1'b0, den[k-1]};

      always_ff @(posedge clk) begin
        if (rst) begin
          v[k] <= 1'b0;
        end else if (rdy[k]) begin
          v[k] <= v[k-1];
        end
      end

      always_ff @(posedge clk) begin
        if (rdy[k] && v[k-1]) begin
          meta[k] <= meta[k-1];
          den[k]  <= den[k-1];
          rem[k]  <= ge ? diff[TW-1:0] : cand[TW-1:0];
          q[k]    <= {q[k-1][FRAC_BITS-1:0], ge};
        end
      end
    end
  endgenerate

  always_ff @(posedge clk) begin
    if (rst) begin
      v[S-1] <= 1'b0;
    end else if (rdy[S-1]) begin
      v[S-1] <= v[S-2];
    end
  end

  always_ff @(posedge clk) begin
    if (rdy[S-1] && v[S-2]) begin
      meta[S-1] <= meta[NQ];
      wl_f      <= q[NQ];
      wh_f      <= meta[NQ][0] ? '0 : ONE - q[NQ];
    end
  end

endmodule

>>> hw/rtl/ilw_check.sv
`include "interval_locate_interp_weights_defines.svh"

module ilw_check (
  input logic                         clk,
  input logic                         rst,
  input logic                         m_tvalid,
  input logic                         m_tready,
  input logic [ilw_pkg::M_DATA_W-1:0] m_tdata,
  input logic [1:0]                   m_tuser
);

  localparam int WH_LSB = 29;
  localparam int WH_MSB = WH_LSB + ilw_pkg::WGT_W - 1;

  // a result waiting for the sink keeps its value
  `ILW_ASSERT(a_out_hold, m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser), "result changed while stalled")

  // a time outside the table gives zero indices and weights
  `ILW_ASSERT(a_range_zero, m_tvalid && (m_tuser == ilw_pkg::ST_BELOW || m_tuser == ilw_pkg::ST_ABOVE) |-> m_tdata == '0, "out of range result not zero")

  // a flat interval puts no weight on the later point
  `ILW_ASSERT(a_flat_high, m_tvalid && m_tuser == ilw_pkg::ST_FLAT |-> m_tdata[WH_MSB:WH_LSB] == '0, "flat interval with later weight")

  // nothing is offered right after reset
  `ILW_ASSERT_ALWAYS(a_reset_idle, $past(rst) |-> !m_tvalid, "result offered after reset")

endmodule

bind interval_locate_interp_weights ilw_check u_check (
  .clk      (clk),
  .rst      (rst),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tuser  (m_tuser)
);
